@@ rtl/core/msr_pkg.sv @@
// Package with the shared types and constants of the motor speed ramp unit.
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

  // Field widths.
  localparam int unsigned LevelW   = 7;
  localparam int unsigned CommandW = 4;
  localparam int unsigned PinsW    = 2;
  localparam int unsigned CfgIdxW  = 2;

  // Reset values of the configuration registers.
  localparam logic [LevelW-1:0] RampStepRst   = LevelW'(2);
  localparam logic [LevelW-1:0] CoarseStepRst = LevelW'(10);
  localparam logic [LevelW-1:0] MaxSpeedRst   = LevelW'(100);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COARSE_STEP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED   = 2'd2;

  // Item kinds.
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  // Drive pin codes.
  localparam logic [PinsW-1:0] PINS_OFF = 2'b00;
  localparam logic [PinsW-1:0] PINS_FWD = 2'b01;
  localparam logic [PinsW-1:0] PINS_BWD = 2'b10;

  // Command codes.
  typedef enum logic [CommandW-1:0] {
    CMD_REVERSE = 4'd0,
    CMD_ENABLE  = 4'd1,
    CMD_STOP    = 4'd2,
    CMD_UP1     = 4'd3,
    CMD_UPC     = 4'd4,
    CMD_DOWN1   = 4'd5,
    CMD_DOWNC   = 4'd6,
    CMD_MAX     = 4'd7,
    CMD_ZERO    = 4'd8
  } cmd_e;

  // Input word.
  typedef struct packed {
    logic                mode;
    logic [CommandW-1:0] command;
  } msr_in_t;

  // Result word.
  typedef struct packed {
    logic [LevelW-1:0] duty;
    logic              pwm_enable;
    logic [PinsW-1:0]  drive_pins;
    logic [LevelW-1:0] target_level;
    logic              wanted_forward;
    logic              actual_forward;
    logic              drive_on;
  } msr_out_t;

  // Configuration seen by the step logic.
  typedef struct packed {
    logic [LevelW-1:0] ramp_step;
    logic [LevelW-1:0] coarse_step;
    logic [LevelW-1:0] max_speed;
  } msr_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/msr_cfg_regs.sv @@
// Configuration register file of the motor speed ramp unit.
`timescale 1ns / 1ps
`default_nettype none

module msr_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [msr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [msr_pkg::LevelW-1:0]    cfg_data_i,
  output msr_pkg::msr_cfg_t                  cfg_o
);

  msr_pkg::msr_cfg_t cfg_q;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step   <= msr_pkg::RampStepRst;
      cfg_q.coarse_step <= msr_pkg::CoarseStepRst;
      cfg_q.max_speed   <= msr_pkg::MaxSpeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msr_pkg::CFG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_data_i;
        msr_pkg::CFG_COARSE_STEP: cfg_q.coarse_step <= cfg_data_i;
        msr_pkg::CFG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/msr_core.sv @@
// Drive state registers and the single-pass step logic for one word.
`timescale 1ns / 1ps
`default_nettype none

module msr_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire msr_pkg::msr_in_t   item_i,
  input  wire msr_pkg::msr_cfg_t  cfg_i,
  output msr_pkg::msr_out_t       result_o
);

  localparam int unsigned W = msr_pkg::LevelW;

  logic [W-1:0] target_q, target_d;
  logic [W-1:0] duty_q, duty_d;
  logic         enabled_q, enabled_d;
  logic         want_fwd_q, want_fwd_d;
  logic         real_fwd_q, real_fwd_d;

  logic [W:0]   cmd_level;
  logic [W-1:0] dn_coarse;
  logic [W-1:0] dn_one;
  logic [W-1:0] diff_up;
  logic [W-1:0] diff_dn;
  logic [W-1:0] rev_duty;
  logic         pwm;
  logic [msr_pkg::PinsW-1:0] pins;

  // Candidate target values; downward steps stop at zero.
  assign dn_one    = (target_q == '0) ? '0 : target_q - W'(1);
  assign dn_coarse = (target_q > cfg_i.coarse_step) ? target_q - cfg_i.coarse_step : '0;
  assign diff_up   = target_q - duty_q;
  assign diff_dn   = duty_q - target_q;
  assign rev_duty  = (duty_q > cfg_i.ramp_step) ? duty_q - cfg_i.ramp_step : '0;

  // Unclamped target after a command; one extra bit holds upward overflow.
  always_comb begin
    cmd_level = {1'b0, target_q};
    case (msr_pkg::cmd_e'(item_i.command))
      msr_pkg::CMD_UP1:   cmd_level = {1'b0, target_q} + (W+1)'(1);
      msr_pkg::CMD_UPC:   cmd_level = {1'b0, target_q} + {1'b0, cfg_i.coarse_step};
      msr_pkg::CMD_DOWN1: cmd_level = {1'b0, dn_one};
      msr_pkg::CMD_DOWNC: cmd_level = {1'b0, dn_coarse};
      msr_pkg::CMD_MAX:   cmd_level = {1'b0, cfg_i.max_speed};
      msr_pkg::CMD_ZERO:  cmd_level = '0;
      default:            cmd_level = {1'b0, target_q};
    endcase
  end

  // Next state and the pin outputs: for a tick from the pre-step state, for a command from the state after it.
  always_comb begin
    target_d   = target_q;
    duty_d     = duty_q;
    enabled_d  = enabled_q;
    want_fwd_d = want_fwd_q;
    real_fwd_d = real_fwd_q;
    pwm        = 1'b0;
    pins       = msr_pkg::PINS_OFF;
    if (item_i.mode == msr_pkg::MODE_COMMAND) begin
      unique case (msr_pkg::cmd_e'(item_i.command))
        msr_pkg::CMD_REVERSE: want_fwd_d = !want_fwd_q;
        msr_pkg::CMD_ENABLE:  enabled_d  = 1'b1;
        msr_pkg::CMD_STOP:    enabled_d  = 1'b0;
        default: ;
      endcase
      // Every command saturates the target to the speed limit.
      target_d = (cmd_level > {1'b0, cfg_i.max_speed}) ? cfg_i.max_speed : cmd_level[W-1:0];
      // Pins follow the state after the command.
      pwm  = enabled_d && (duty_q != '0);
      pins = !enabled_d ? msr_pkg::PINS_OFF
           : (real_fwd_q ? msr_pkg::PINS_FWD : msr_pkg::PINS_BWD);
    end else if (!enabled_q) begin
      duty_d = '0;
    end else begin
      pwm  = (duty_q != '0);
      pins = real_fwd_q ? msr_pkg::PINS_FWD : msr_pkg::PINS_BWD;
      if (want_fwd_q != real_fwd_q) begin
        // Reversal pending: ramp down, flip once the duty reaches zero.
        duty_d = rev_duty;
        if (rev_duty == '0) begin
          real_fwd_d = want_fwd_q;
        end
      end else if (target_q > duty_q) begin
        duty_d = duty_q + ((diff_up > cfg_i.ramp_step) ? cfg_i.ramp_step : diff_up);
      end else if (target_q < duty_q) begin
        duty_d = duty_q - ((diff_dn > cfg_i.ramp_step) ? cfg_i.ramp_step : diff_dn);
      end
    end
  end

  // State update, one word per cycle while step_i is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      duty_q     <= '0;
      enabled_q  <= 1'b0;
      want_fwd_q <= 1'b1;
      real_fwd_q <= 1'b1;
    end else if (step_i) begin
      target_q   <= target_d;
      duty_q     <= duty_d;
      enabled_q  <= enabled_d;
      want_fwd_q <= want_fwd_d;
      real_fwd_q <= real_fwd_d;
    end
  end

  // Result word of this step.
  always_comb begin
    result_o.duty           = duty_d;
    result_o.pwm_enable     = pwm;
    result_o.drive_pins     = pins;
    result_o.target_level   = target_d;
    result_o.wanted_forward = want_fwd_d;
    result_o.actual_forward = real_fwd_d;
    result_o.drive_on       = enabled_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/motor_speed_ramp_with_reversal_unit.sv @@
// Top level of the motor speed ramp unit with direction reversal.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is a ramp tick or a command event and yields exactly one result
// word. A word is captured in an input register, processed by the step logic
// against the drive state in one pass, and written to the result register, so the
// unit takes one word per cycle while the output is not stalled; the single state
// update per cycle in the step logic sets that rate. The user must write the
// configuration registers through the plain write port only while the unit is
// idle (the block itself does not enforce this); they take effect on the next word.
module motor_speed_ramp_with_reversal_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire msr_pkg::msr_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output msr_pkg::msr_out_t                out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [msr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [msr_pkg::LevelW-1:0]  cfg_data_i
);

  msr_pkg::msr_cfg_t cfg;
  msr_pkg::msr_in_t  item_q;
  msr_pkg::msr_out_t result;
  msr_pkg::msr_out_t out_q;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              out_free;
  logic              step;
  logic              in_take;

  msr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the result register frees when empty or when taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  msr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (step) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A word leaving the input register lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> out_valid_q)
    else $error("stepped word did not reach the result register");

  // The input side stalls only while a word waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> item_valid_q)
    else $error("input stalled with an empty input register");

  // A disabled drive never shows pins or a connected PWM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_q.drive_on) |->
      (out_q.drive_pins == msr_pkg::PINS_OFF && !out_q.pwm_enable))
    else $error("pins driven while the drive is disabled");

  // Pin code is never both directions at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (out_q.drive_pins != (msr_pkg::PINS_FWD | msr_pkg::PINS_BWD)))
    else $error("both direction pins set");

endmodule

`default_nettype wire
